@@ sv/utf8_sequence_classifier_assert.svh @@
// Assertion macros for the UTF-8 sequence classifier.
// Expects aclk and aresetn in the scope of use.
`ifndef UTF8_SEQUENCE_CLASSIFIER_ASSERT_SVH
`define UTF8_SEQUENCE_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define U8SC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8 classifier: same-cycle check failed");

// next-cycle implication
`define U8SC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 classifier: next-cycle check failed");

`endif

@@ sv/u8sc_pkg.sv @@
// Shared types and constants for the UTF-8 sequence classifier.
// No dependencies.
package u8sc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 32;
    localparam int OUT_WIDTH           = 32;
    localparam int ACC_WIDTH           = 21;
    localparam int SEQ_WIDTH           = 4;
    localparam int M_TDATA_WIDTH       = 104;

    // config register indexes
    localparam logic REG_BREAK_ON_BAD     = 1'b0;
    localparam logic REG_BREAK_ON_STRANGE = 1'b1;

    // sequence progress codes; the last code of each group awaits the final byte
    localparam logic [SEQ_WIDTH-1:0] SEQ_IDLE     = 4'd0;
    localparam logic [SEQ_WIDTH-1:0] SEQ_2B_LAST  = 4'd1;
    localparam logic [SEQ_WIDTH-1:0] SEQ_3B_FIRST = 4'd2;
    localparam logic [SEQ_WIDTH-1:0] SEQ_3B_LAST  = 4'd3;
    localparam logic [SEQ_WIDTH-1:0] SEQ_4B_FIRST = 4'd4;
    localparam logic [SEQ_WIDTH-1:0] SEQ_4B_LAST  = 4'd6;
    localparam logic [SEQ_WIDTH-1:0] SEQ_5B_FIRST = 4'd7;
    localparam logic [SEQ_WIDTH-1:0] SEQ_5B_LAST  = 4'd10;
    localparam logic [SEQ_WIDTH-1:0] SEQ_6B_FIRST = 4'd11;
    localparam logic [SEQ_WIDTH-1:0] SEQ_6B_LAST  = 4'd15;

    localparam logic [ACC_WIDTH-1:0] MIN_2B    = 21'h000080;
    localparam logic [ACC_WIDTH-1:0] MIN_3B    = 21'h000800;
    localparam logic [ACC_WIDTH-1:0] SURR_LO   = 21'h00D800;
    localparam logic [ACC_WIDTH-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [ACC_WIDTH-1:0] MIN_4B    = 21'h010000;
    localparam logic [ACC_WIDTH-1:0] MAX_CODE  = 21'h10FFFF;

    typedef struct packed {
        logic good;
        logic bad;
        logic strange;
        logic still_open;
    } seq_evt_t;

    typedef struct packed {
        logic                 stopped;
        logic [OUT_WIDTH-1:0] strange;
        logic [OUT_WIDTH-1:0] bad;
        logic [OUT_WIDTH-1:0] good;
    } result_t;

endpackage

@@ sv/u8sc_seq.sv @@
// Sequence tracker: lead/continuation decode, payload accumulator, end-of-sequence checks.
// Depends on u8sc_pkg.
module u8sc_seq
    import u8sc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 last,
    input  logic                 halted,
    input  logic [7:0]           data_byte,
    output seq_evt_t             evt,
    output logic [SEQ_WIDTH-1:0] seq_state
);

    logic [SEQ_WIDTH-1:0] state_reg, state_next, state_proc;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next, acc_proc, acc_shift;

    assign acc_shift = {acc_reg[ACC_WIDTH-7:0], data_byte[5:0]};

    always_comb begin
        state_proc = state_reg;
        acc_proc   = acc_reg;
        evt        = '0;
        if (state_reg == SEQ_IDLE) begin
            priority if (data_byte[7] == 1'b0) begin
                state_proc = SEQ_IDLE;
            end else if (data_byte[7:6] == 2'b10) begin
                evt.bad = 1'b1;
            end else if (data_byte[7:5] == 3'b110) begin
                acc_proc   = ACC_WIDTH'(data_byte[4:0]);
                state_proc = SEQ_2B_LAST;
            end else if (data_byte[7:4] == 4'b1110) begin
                acc_proc   = ACC_WIDTH'(data_byte[3:0]);
                state_proc = SEQ_3B_FIRST;
            end else if (data_byte[7:3] == 5'b11110) begin
                acc_proc   = ACC_WIDTH'(data_byte[2:0]);
                state_proc = SEQ_4B_FIRST;
            end else if (data_byte[7:2] == 6'b111110) begin
                acc_proc   = ACC_WIDTH'(data_byte[1:0]);
                state_proc = SEQ_5B_FIRST;
            end else if (data_byte[7:1] == 7'b1111110) begin
                acc_proc   = ACC_WIDTH'(data_byte[0]);
                state_proc = SEQ_6B_FIRST;
            end else begin
                state_proc = SEQ_IDLE;
            end
        end else if (data_byte[7:6] != 2'b10) begin
            evt.bad    = 1'b1;
            state_proc = SEQ_IDLE;
        end else begin
            acc_proc = acc_shift;
            unique case (state_reg)
                SEQ_2B_LAST: begin
                    evt.strange = acc_shift < MIN_2B;
                    evt.good    = !(acc_shift < MIN_2B);
                    state_proc  = SEQ_IDLE;
                end
                SEQ_3B_LAST: begin
                    evt.strange = (acc_shift < MIN_3B)
                               || (acc_shift >= SURR_LO && acc_shift <= SURR_HI);
                    evt.good    = !evt.strange;
                    state_proc  = SEQ_IDLE;
                end
                SEQ_4B_LAST: begin
                    evt.strange = (acc_shift < MIN_4B) || (acc_shift > MAX_CODE);
                    evt.good    = !evt.strange;
                    state_proc  = SEQ_IDLE;
                end
                SEQ_5B_LAST, SEQ_6B_LAST: begin
                    evt.strange = 1'b1;
                    state_proc  = SEQ_IDLE;
                end
                default: begin
                    state_proc = state_reg + 1'b1;
                end
            endcase
        end
        evt.still_open = state_proc != SEQ_IDLE;
    end

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        if (step) begin
            if (last) begin
                state_next = SEQ_IDLE;
                acc_next   = '0;
            end else if (!halted) begin
                state_next = state_proc;
                acc_next   = acc_proc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            acc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    assign seq_state = state_reg;

endmodule

@@ sv/u8sc_tally.sv @@
// Saturating totals, break-mode halt and end-of-buffer result.
// Depends on u8sc_pkg.
module u8sc_tally
    import u8sc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  logic     last,
    input  logic     break_on_bad,
    input  logic     break_on_strange,
    input  seq_evt_t evt,
    output logic     halted,
    output result_t  result
);

    logic [COUNT_WIDTH-1:0] good_reg, good_next, good_a;
    logic [COUNT_WIDTH-1:0] bad_reg, bad_next, bad_a, bad_f;
    logic [COUNT_WIDTH-1:0] strange_reg, strange_next, strange_a;
    logic                   halted_reg, halted_next, halt_a, take;

    assign take = !halted_reg;

    always_comb begin
        good_a    = (take && evt.good && !(&good_reg)) ? good_reg + 1'b1 : good_reg;
        bad_a     = (take && evt.bad && !(&bad_reg)) ? bad_reg + 1'b1 : bad_reg;
        strange_a = (take && evt.strange && !(&strange_reg)) ? strange_reg + 1'b1
                                                             : strange_reg;
        halt_a    = halted_reg || (break_on_bad && (bad_a != '0))
                 || (break_on_strange && (strange_a != '0));
        // sequence left open at the end of the buffer
        bad_f     = (last && !halt_a && evt.still_open && !(&bad_a)) ? bad_a + 1'b1 : bad_a;
    end

    always_comb begin
        good_next    = good_reg;
        bad_next     = bad_reg;
        strange_next = strange_reg;
        halted_next  = halted_reg;
        if (step) begin
            if (last) begin
                good_next    = '0;
                bad_next     = '0;
                strange_next = '0;
                halted_next  = 1'b0;
            end else begin
                good_next    = good_a;
                bad_next     = bad_a;
                strange_next = strange_a;
                halted_next  = halt_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg    <= '0;
            bad_reg     <= '0;
            strange_reg <= '0;
            halted_reg  <= 1'b0;
        end else begin
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            strange_reg <= strange_next;
            halted_reg  <= halted_next;
        end
    end

    generate
        if (COUNT_WIDTH > OUT_WIDTH) begin : g_clip
            assign result.good    = (|good_a[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                       : good_a[OUT_WIDTH-1:0];
            assign result.bad     = (|bad_f[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                      : bad_f[OUT_WIDTH-1:0];
            assign result.strange = (|strange_a[COUNT_WIDTH-1:OUT_WIDTH]) ? '1
                                                                : strange_a[OUT_WIDTH-1:0];
        end else begin : g_ext
            assign result.good    = OUT_WIDTH'(good_a);
            assign result.bad     = OUT_WIDTH'(bad_f);
            assign result.strange = OUT_WIDTH'(strange_a);
        end
    endgenerate

    assign result.stopped = halted_reg;
    assign halted         = halted_reg;

endmodule

@@ sv/utf8_sequence_classifier.sv @@
// Top level of the UTF-8 sequence classifier: config registers, output and skid registers.
// Depends on u8sc_pkg, u8sc_seq, u8sc_tally, utf8_sequence_classifier_assert.svh.
//
// channel  | direction | payload
// ---------+-----------+---------------------------------------------------
// s_*      | in        | tdata: data_byte; tlast: last_byte
// m_*      | out       | tdata: good, bad, strange counts, stopped_early
// cfg_*    | in        | write of break_on_bad (0) / break_on_strange (1)
//
// One byte per cycle while s_tready is high; the state update is one pass of decode logic per byte.
// The result is registered at the edge that accepts the request carrying tlast.
// A skid register holds one more result while m_tready is low.
// s_tready drops only while both result slots are full; it is a register output.
// aresetn is synchronous; it clears sequence state, totals and config.
`include "utf8_sequence_classifier_assert.svh"

module utf8_sequence_classifier
    import u8sc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [7:0] data_byte
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [31:0] good_count, [63:32] bad_count, [95:64] strange_count,
    // [96] stopped_early, [103:97] zero
    output logic [M_TDATA_WIDTH-1:0] m_tdata,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_addr,
    input  logic                     cfg_wdata
);

    logic                  s_accept;
    logic                  s_last_acc;
    logic                  m_take;
    logic                  brk_bad_reg, brk_strange_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [3*OUT_WIDTH:0]  m_data_reg, m_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [3*OUT_WIDTH:0]  skid_data_reg, skid_data_next;
    logic                  halted;
    logic [SEQ_WIDTH-1:0]  seq_state;
    seq_evt_t              evt;
    result_t               result;

    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign s_last_acc = s_accept && s_tlast;
    assign m_take     = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brk_bad_reg     <= 1'b0;
            brk_strange_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BREAK_ON_BAD:     brk_bad_reg     <= cfg_wdata;
                REG_BREAK_ON_STRANGE: brk_strange_reg <= cfg_wdata;
            endcase
        end
    end

    u8sc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s_accept),
        .last      (s_tlast),
        .halted    (halted),
        .data_byte (s_tdata),
        .evt       (evt),
        .seq_state (seq_state)
    );

    u8sc_tally #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (s_accept),
        .last             (s_tlast),
        .break_on_bad     (brk_bad_reg),
        .break_on_strange (brk_strange_reg),
        .evt              (evt),
        .halted           (halted),
        .result           (result)
    );

    // skid slot drains into the output slot first, so order is kept
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!m_valid_reg || m_take) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (s_last_acc) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (s_last_acc) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        m_data_reg    <= m_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(m_data_reg);

    `U8SC_ASSERT_NEXT(a_result_follows_last, s_accept && s_tlast, m_tvalid)
    `U8SC_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, m_valid_reg)
    `U8SC_ASSERT_NEXT(a_idle_holds_state, !s_accept, $stable(seq_state) && $stable(halted))

endmodule
